// ===== design/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch swipe detector package
// Shared types, constants and register indexes for the swipe detector.
// ----------------------------------------------------------------------------
package tsd_pkg;

  // Widths of the report fields and of the rotated panel coordinates.
  localparam int unsigned RawW   = 12;
  localparam int unsigned CountW = 4;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CoordW = 14;
  localparam int unsigned MagW   = 13;

  // Largest panel coordinate; a mirrored axis maps r to this minus r.
  localparam logic signed [CoordW-1:0] PanelMax = 14'sd239;

  // Configuration register indexes.
  localparam logic [1:0] CfgRotation = 2'd0;
  localparam logic [1:0] CfgMinSwipe = 2'd1;
  localparam logic [1:0] CfgMaxDur   = 2'd2;

  // Configuration reset values.
  localparam logic [1:0]       RotationRst = 2'd0;
  localparam logic [MagW-1:0]  MinSwipeRst = 13'd45;
  localparam logic [TimeW-1:0] MaxDurRst   = 32'd1000;

  // Quarter turn codes.
  localparam logic [1:0] Rot0   = 2'd0;
  localparam logic [1:0] Rot90  = 2'd1;
  localparam logic [1:0] Rot180 = 2'd2;
  localparam logic [1:0] Rot270 = 2'd3;

  // Live configuration.
  typedef struct packed {
    logic [1:0]       rotation;
    logic [MagW-1:0]  min_swipe_pixels;
    logic [TimeW-1:0] max_duration_ms;
  } tsd_cfg_t;

  // One touch controller report.
  typedef struct packed {
    logic              read_ok;
    logic [CountW-1:0] point_count;
    logic [RawW-1:0]   raw_x;
    logic [RawW-1:0]   raw_y;
    logic [TimeW-1:0]  time_ms;
  } tsd_report_t;

  // One gesture result.
  typedef struct packed {
    logic swipe_right;
    logic swipe_detected;
  } tsd_result_t;

endpackage

// ===== design/tsd_gesture.sv =====
// ----------------------------------------------------------------------------
// Touch swipe gesture tracker
// Holds the touch state, rotates points and classifies each release.
// ----------------------------------------------------------------------------
module tsd_gesture
  import tsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  tsd_report_t report_i,
  input  tsd_cfg_t    cfg_i,
  output tsd_result_t result_o
);

  logic                     was_touched_q, was_touched_d;
  logic signed [CoordW-1:0] start_x_q, start_y_q, last_x_q, last_y_q;
  logic [TimeW-1:0]         start_time_q;

  logic signed [CoordW-1:0] rx, ry, px, py;
  logic signed [CoordW-1:0] dx, dy;
  logic [MagW-1:0]          adx, ady;
  logic [MagW:0]            ady_bias;
  logic [TimeW-1:0]         dur;
  logic                     touching, release_ev, passes;

  // Rotate the raw point by the configured quarter turns.
  assign rx = $signed({{(CoordW-RawW){1'b0}}, report_i.raw_x});
  assign ry = $signed({{(CoordW-RawW){1'b0}}, report_i.raw_y});

  always_comb begin
    unique case (cfg_i.rotation)
      Rot90: begin
        px = ry;
        py = PanelMax - rx;
      end
      Rot180: begin
        px = PanelMax - rx;
        py = PanelMax - ry;
      end
      Rot270: begin
        px = PanelMax - ry;
        py = rx;
      end
      default: begin
        px = rx;
        py = ry;
      end
    endcase
  end

  // Travel and duration of the gesture that a release would end.
  assign dx  = last_x_q - start_x_q;
  assign dy  = last_y_q - start_y_q;
  assign adx = dx[CoordW-1] ? MagW'(-dx) : MagW'(dx);
  assign ady = dy[CoordW-1] ? MagW'(-dy) : MagW'(dy);
  assign ady_bias = {1'b0, ady} + {3'b000, ady[MagW-1:2]};
  assign dur = report_i.time_ms - start_time_q;

  assign passes = (dur < cfg_i.max_duration_ms) &&
                  (adx >= cfg_i.min_swipe_pixels) &&
                  ({1'b0, adx} > ady_bias);

  assign touching   = accept_i && report_i.read_ok && (report_i.point_count != '0);
  assign release_ev = accept_i && report_i.read_ok && (report_i.point_count == '0) &&
                      was_touched_q;

  // Result for the report now being taken.
  always_comb begin
    result_o.swipe_detected = release_ev && passes;
    result_o.swipe_right    = release_ev && passes && !dx[CoordW-1];
  end

  // Touch flag follows presses and releases.
  always_comb begin
    was_touched_d = was_touched_q;
    if (touching) begin
      was_touched_d = 1'b1;
    end else if (release_ev) begin
      was_touched_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_touched_q <= 1'b0;
    end else begin
      was_touched_q <= was_touched_d;
    end
  end

  // Point and time capture; only read while a touch is held.
  always_ff @(posedge clk_i) begin
    if (touching) begin
      if (!was_touched_q) begin
        start_x_q    <= px;
        start_y_q    <= py;
        start_time_q <= report_i.time_ms;
      end
      last_x_q <= px;
      last_y_q <= py;
    end
  end

endmodule

// ===== design/touch_swipe_detector.sv =====
// ----------------------------------------------------------------------------
// Touch swipe detector
// Classifies polled touch reports into horizontal swipes, one result each.
// ----------------------------------------------------------------------------
// A result is registered in the output register, or in the skid entry when
// the output is stalled, before it shows on the master side. Input takes
// one report per cycle while the skid entry of the two-entry output buffer
// is empty. Reset (asynchronous, active low) clears the touch flag and both
// buffer entries and loads the defaults: no rotation, 45 pixels, 1000 ms.
module touch_swipe_detector
  import tsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  // Report stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: point_count[3:0], raw_x[15:4], raw_y[27:16], time_ms[59:28], zero
  input  logic [63:0] s_axis_tdata_i,
  // tuser: read_ok[0]
  input  logic        s_axis_tuser_i,
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: swipe_detected[0], swipe_right[1], zero
  output logic [7:0]  m_axis_tdata_o
);

  tsd_cfg_t    cfg_q;
  tsd_report_t report;
  tsd_result_t result;
  tsd_result_t out_data_q, out_data_d, skid_data_q, skid_data_d;
  logic        out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic        s_acc, m_take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation         <= RotationRst;
      cfg_q.min_swipe_pixels <= MinSwipeRst;
      cfg_q.max_duration_ms  <= MaxDurRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgRotation: cfg_q.rotation         <= cfg_wdata_i[1:0];
        CfgMinSwipe: cfg_q.min_swipe_pixels <= cfg_wdata_i[MagW-1:0];
        CfgMaxDur:   cfg_q.max_duration_ms  <= cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the report.
  assign report.read_ok     = s_axis_tuser_i;
  assign report.point_count = s_axis_tdata_i[3:0];
  assign report.raw_x       = s_axis_tdata_i[15:4];
  assign report.raw_y       = s_axis_tdata_i[27:16];
  assign report.time_ms     = s_axis_tdata_i[59:28];

  assign s_axis_tready_o = !skid_valid_q;
  assign s_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_take = out_valid_q && m_axis_tready_i;

  tsd_gesture u_gesture (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_acc),
    .report_i (report),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Output register with a skid entry behind it.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (m_take) begin
      out_valid_d = 1'b0;
    end
    if (skid_valid_q && m_take) begin
      out_valid_d  = 1'b1;
      out_data_d   = skid_data_q;
      skid_valid_d = 1'b0;
    end else if (s_acc) begin
      if (!out_valid_q || m_take) begin
        out_valid_d = 1'b1;
        out_data_d  = result;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, out_data_q.swipe_right, out_data_q.swipe_detected};

endmodule

// ===== design/tsd_checker.sv =====
// ----------------------------------------------------------------------------
// Touch swipe detector checker
// Port-level assertions on the swipe detector, attached by a bind.
// ----------------------------------------------------------------------------
module tsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_i,
  input logic       m_axis_tvalid_i,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_i
);

  // The input only stalls while a result is waiting.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_i |-> m_axis_tvalid_i)
    else $error("input stalled with no result pending");

  // A transaction into an empty output shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_i && !m_axis_tvalid_i) |=> m_axis_tvalid_i)
    else $error("result missing one cycle after report");

  // A direction is only reported with a detection, and padding stays zero.
  a_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> ((m_axis_tdata_i[7:2] == 6'd0) &&
                         (!m_axis_tdata_i[1] || m_axis_tdata_i[0])))
    else $error("malformed result");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=> (m_axis_tvalid_i && $stable(m_axis_tdata_i)))
    else $error("stalled result changed");

endmodule

bind touch_swipe_detector tsd_checker u_tsd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

// ===== sim/touch_swipe_detector_tb.sv =====
// ----------------------------------------------------------------------------
// Touch swipe detector testbench
// Drives touch reports into the detector and checks every gesture result
// against a cycle-free predictor of the rotation, gesture tracking and swipe
// tests. Directed gestures cover the corner cases. Random phases follow, each
// with its own configuration, random idling on both streams and one stretch
// with no idling at all.
// ----------------------------------------------------------------------------
module touch_swipe_detector_tb;
  import tsd_pkg::*;

  localparam int StallLimit = 3000;

  logic        clk_i;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [1:0]  cfg_addr    = CfgRotation;
  logic [31:0] cfg_wdata   = '0;
  logic        s_valid     = 1'b0;
  logic [63:0] s_tdata     = '0;
  logic        s_tuser     = 1'b0;
  logic        m_ready     = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;

  // Configuration as the testbench has written it.
  logic [1:0]       cfg_rot = RotationRst;
  logic [MagW-1:0]  cfg_min = MinSwipeRst;
  logic [TimeW-1:0] cfg_max = MaxDurRst;

  // Gesture tracking state of the predictor.
  logic                     touch_active = 1'b0;
  logic signed [CoordW-1:0] start_px = '0;
  logic signed [CoordW-1:0] start_py = '0;
  logic signed [CoordW-1:0] last_px  = '0;
  logic signed [CoordW-1:0] last_py  = '0;
  logic [TimeW-1:0]         start_ms = '0;

  tsd_result_t swipe_q[$];
  int          errors       = 0;
  int          stall_cycles = 0;
  bit          no_idle      = 1'b0;

  touch_swipe_detector u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    // tdata: point_count[3:0], raw_x[15:4], raw_y[27:16], time_ms[59:28], zero
    .s_axis_tdata_i  (s_tdata),
    // tuser: read_ok[0]
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    // tdata: swipe_detected[0], swipe_right[1], zero
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the result of one report and advances the gesture state.
  function automatic tsd_result_t predict_swipe(input tsd_report_t rpt);
    tsd_result_t      res;
    int               rx, ry, px, py, dx, dy, adx, ady;
    logic [TimeW-1:0] elapsed;
    res = '0;
    rx  = int'(rpt.raw_x);
    ry  = int'(rpt.raw_y);
    if (!rpt.read_ok) return res;
    if (rpt.point_count != 0) begin
      case (cfg_rot)
        Rot90: begin
          px = ry;
          py = int'(PanelMax) - rx;
        end
        Rot180: begin
          px = int'(PanelMax) - rx;
          py = int'(PanelMax) - ry;
        end
        Rot270: begin
          px = int'(PanelMax) - ry;
          py = rx;
        end
        default: begin
          px = rx;
          py = ry;
        end
      endcase
      if (!touch_active) begin
        start_px = px[CoordW-1:0];
        start_py = py[CoordW-1:0];
        start_ms = rpt.time_ms;
      end
      last_px      = px[CoordW-1:0];
      last_py      = py[CoordW-1:0];
      touch_active = 1'b1;
      return res;
    end
    // A release only counts when a touch is in progress.
    if (!touch_active) return res;
    touch_active = 1'b0;
    dx      = int'(last_px) - int'(start_px);
    dy      = int'(last_py) - int'(start_py);
    adx     = (dx < 0) ? -dx : dx;
    ady     = (dy < 0) ? -dy : dy;
    elapsed = rpt.time_ms - start_ms;
    if (elapsed < cfg_max && adx >= int'(cfg_min) && adx > ady + (ady >> 2)) begin
      res.swipe_detected = 1'b1;
      res.swipe_right    = (dx > 0);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch in %s: expected %0d, got %0d at %0t", what, want, got, $time);
    errors++;
  endtask

  // Predict on each report transaction, then check each result transaction.
  always @(posedge clk_i) begin : scoreboard
    tsd_report_t rpt;
    tsd_result_t want;
    if (rst_n) begin
      if (s_valid && s_axis_tready_o) begin
        rpt.read_ok     = s_tuser;
        rpt.point_count = s_tdata[3:0];
        rpt.raw_x       = s_tdata[15:4];
        rpt.raw_y       = s_tdata[27:16];
        rpt.time_ms     = s_tdata[59:28];
        swipe_q.push_back(predict_swipe(rpt));
      end
      if (m_axis_tvalid_o && m_ready) begin
        if (swipe_q.size() == 0) begin
          report_mismatch("result count (none pending)", 0, 1);
        end else begin
          want = swipe_q.pop_front();
          if (m_axis_tdata_o[0] !== want.swipe_detected)
            report_mismatch("swipe_detected", int'(want.swipe_detected),
                            int'(m_axis_tdata_o[0]));
          if (m_axis_tdata_o[1] !== want.swipe_right)
            report_mismatch("swipe_right", int'(want.swipe_right),
                            int'(m_axis_tdata_o[1]));
          if (m_axis_tdata_o[7:2] !== 6'd0)
            report_mismatch("tdata padding", 0, int'(m_axis_tdata_o[7:2]));
        end
      end
    end
  end

  // The receiver stalls at random unless idling is switched off.
  always @(posedge clk_i) begin
    m_ready <= no_idle || ($urandom_range(0, 99) >= 31);
  end

  // Ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin : watchdog
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one report and returns at the edge where it is taken. Valid stays
  // high afterwards so that back-to-back reports need no extra assignment.
  task automatic send_report(input logic ok, input logic [CountW-1:0] count,
                             input logic [RawW-1:0] rx, input logic [RawW-1:0] ry,
                             input logic [TimeW-1:0] ms);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= ok;
    s_tdata <= {4'd0, ms, ry, rx, count};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (swipe_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      CfgRotation: cfg_rot = data[1:0];
      CfgMinSwipe: cfg_min = data[MagW-1:0];
      CfgMaxDur:   cfg_max = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [1:0] rot, input logic [MagW-1:0] min_px,
                            input logic [TimeW-1:0] max_ms);
    wait_idle();
    write_reg(CfgRotation, 32'(rot));
    write_reg(CfgMinSwipe, 32'(min_px));
    write_reg(CfgMaxDur, max_ms);
  endtask

  // Touch down, move to the end point, lift off after span milliseconds.
  task automatic swipe_gesture(input int x0, input int y0, input int x1, input int y1,
                               input logic [TimeW-1:0] t0, input logic [TimeW-1:0] span);
    send_report(1'b1, 4'd1, RawW'(x0), RawW'(y0), t0);
    send_report(1'b1, 4'd2, RawW'(x1), RawW'(y1), t0 + span / 2);
    send_report(1'b1, 4'd0, RawW'($urandom_range(0, 4095)), RawW'($urandom_range(0, 4095)),
                t0 + span);
  endtask

  // A raw coordinate moved by up to reach pixels either way, kept on the bus range.
  function automatic int nudge(input int base, input int reach);
    int v;
    v = int'($urandom_range(0, 2 * reach)) - reach + base;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // A complete gesture with random content, sometimes with failed reads inside.
  task automatic random_gesture(inout int sent);
    int               x0, y0, x1, y1, steps;
    bit               along_y;
    logic [TimeW-1:0] t0, span;
    x0      = $urandom_range(0, 1) ? $urandom_range(0, 239) : $urandom_range(0, 4095);
    y0      = $urandom_range(0, 1) ? $urandom_range(0, 239) : $urandom_range(0, 4095);
    along_y = 1'($urandom_range(0, 1));
    x1      = nudge(x0, along_y ? 60 : 700);
    y1      = nudge(y0, along_y ? 700 : 60);
    t0      = $urandom();
    span    = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1500);
    steps   = $urandom_range(0, 3);
    send_report(1'b1, CountW'($urandom_range(1, 15)), RawW'(x0), RawW'(y0), t0);
    for (int k = 0; k < steps; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_report(1'b0, CountW'($urandom_range(0, 15)), RawW'($urandom_range(0, 4095)),
                    RawW'($urandom_range(0, 4095)), $urandom());
      else
        send_report(1'b1, CountW'($urandom_range(1, 15)), RawW'(nudge(x1, 200)),
                    RawW'(nudge(y1, 200)), t0 + span / 4);
    end
    send_report(1'b1, CountW'($urandom_range(1, 15)), RawW'(x1), RawW'(y1), t0 + span / 2);
    send_report(1'b1, 4'd0, RawW'($urandom_range(0, 4095)), RawW'($urandom_range(0, 4095)),
                t0 + span);
    sent += steps + 3;
  endtask

  // One random phase under a fixed configuration.
  task automatic run_phase(input logic [1:0] rot, input logic [MagW-1:0] min_px,
                           input logic [TimeW-1:0] max_ms, input int n_items,
                           input bit quiet);
    int sent;
    int pick;
    set_config(rot, min_px, max_ms);
    no_idle = quiet;
    sent    = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        random_gesture(sent);
      end else if (pick < 90) begin
        // Noise: any report at all.
        send_report(1'($urandom_range(0, 1)), CountW'($urandom_range(0, 15)),
                    RawW'($urandom_range(0, 4095)), RawW'($urandom_range(0, 4095)),
                    $urandom());
        sent++;
      end else if (pick < 95) begin
        // A touch that is never lifted before the next gesture starts.
        send_report(1'b1, CountW'($urandom_range(1, 15)), RawW'($urandom_range(0, 4095)),
                    RawW'($urandom_range(0, 4095)), $urandom());
        sent++;
      end else begin
        // A lift-off with no touch in progress, unless one was left open.
        send_report(1'b1, 4'd0, RawW'($urandom_range(0, 4095)),
                    RawW'($urandom_range(0, 4095)), $urandom());
        sent++;
      end
      // Now and then let the result stream run dry before going on.
      if ($urandom_range(0, 39) == 0) wait_idle();
    end
    no_idle = 1'b0;
  endtask

  // Corner cases under the reset configuration.
  task automatic test_directed();
    // Lift-off with no touch in progress.
    send_report(1'b1, 4'd0, 12'd4095, 12'd0, 32'd5);
    // A failed read that would be a lift-off must not end the gesture.
    send_report(1'b1, 4'd1, 12'd0, 12'd0, 32'd0);
    send_report(1'b0, 4'd0, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    send_report(1'b1, 4'd15, 12'd100, 12'd10, 32'd100);
    send_report(1'b1, 4'd0, 12'd0, 12'd4095, 32'd200);
    // Full-width swipe to the left, just inside the time limit.
    swipe_gesture(4095, 4095, 0, 4095, 32'd1000, 32'd999);
    // Horizontal travel equal to 1.25 times the vertical travel is not enough.
    swipe_gesture(200, 0, 250, 40, 32'd3000, 32'd10);
    // Duration equal to the limit fails.
    swipe_gesture(0, 0, 300, 0, 32'd5000, 32'd1000);
    // Timestamp wraps during the gesture; travel equals the minimum.
    swipe_gesture(10, 20, 55, 20, 32'hFFFF_FF00, 32'd272);
  endtask

  // Each quarter turn, with a gesture that is horizontal on the rotated panel.
  task automatic test_rotation();
    set_config(Rot90, 13'd45, 32'd1000);
    swipe_gesture(0, 0, 0, 300, 32'd100, 32'd50);
    set_config(Rot180, 13'd45, 32'd1000);
    swipe_gesture(0, 0, 300, 0, 32'd200, 32'd50);
    set_config(Rot270, 13'd45, 32'd1000);
    swipe_gesture(0, 300, 0, 0, 32'd300, 32'd50);
    // With a zero minimum a finger that never moves is still no swipe.
    set_config(Rot270, 13'd0, 32'd1000);
    swipe_gesture(500, 500, 500, 500, 32'd400, 32'd50);
  endtask

  task automatic test_random();
    run_phase(Rot0, 13'd45, 32'd1000, 250, 1'b0);
    run_phase(Rot90, 13'd0, 32'hFFFF_FFFF, 250, 1'b0);
    run_phase(Rot180, 13'd8191, 32'd0, 250, 1'b0);
    run_phase(Rot270, MagW'($urandom_range(0, 200)), $urandom_range(200, 2000), 250, 1'b0);
    run_phase(2'($urandom_range(0, 3)), MagW'($urandom_range(0, 300)),
              $urandom_range(100, 3000), 250, 1'b1);
    run_phase(2'($urandom_range(0, 3)), MagW'($urandom_range(0, 8191)), $urandom(), 250,
              1'b0);
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    test_directed();
    test_rotation();
    test_random();
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tsd_pkg.sv
design/tsd_gesture.sv
design/touch_swipe_detector.sv
design/tsd_checker.sv
sim/touch_swipe_detector_tb.sv
